/* sv/rect_blit_mirror_address_gen_assert.svh */
// Assertion macros for the rectangle blit address generator.
// Used by the top level only; no other dependencies.
`ifndef RECT_BLIT_MIRROR_ADDRESS_GEN_ASSERT_SVH
`define RECT_BLIT_MIRROR_ADDRESS_GEN_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define RBM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rect blit assertion failed");

// Check a condition in the cycle after its trigger
`define RBM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rect blit assertion failed");

`endif

/* sv/rbm_pkg.sv */
// Shared types, constants and the color packing function of the blit writer.
// No dependencies; used by every module of the block.
package rbm_pkg;

    // Field widths
    localparam int FW   = 12;   // frame and extent registers
    localparam int OW   = 11;   // rectangle offsets
    localparam int IDXW = 22;   // framebuffer word index
    localparam int PIXW = 16;   // RGB565 pixel
    localparam int INW  = 24;   // source pixel
    localparam int DW   = ((IDXW + PIXW + 7) / 8) * 8;
    localparam int CIW  = 3;    // config register index

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPW    = 2;
    localparam int QCW    = 3;

    // RGB565 color masks
    localparam logic [PIXW-1:0] MASK_B = 16'h001F;
    localparam logic [PIXW-1:0] MASK_G = 16'h07E0;
    localparam logic [PIXW-1:0] MASK_R = 16'hF800;

    // Reset values of the registers
    localparam logic [FW-1:0] RST_FRAME_WIDTH  = 12'd480;
    localparam logic [FW-1:0] RST_FRAME_HEIGHT = 12'd272;
    localparam logic [FW-1:0] RST_RECT_EXTENT  = 12'd1;

    typedef enum logic [CIW-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_RECT_LEFT     = 3'd2,
        REG_RECT_TOP      = 3'd3,
        REG_RECT_COLS     = 3'd4,
        REG_RECT_ROWS     = 3'd5,
        REG_MIRROR_MODE   = 3'd6,
        REG_SOURCE_FORMAT = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [FW-1:0] frame_width;
        logic [FW-1:0] frame_height;
        logic [OW-1:0] rect_left;
        logic [OW-1:0] rect_top;
        logic [FW-1:0] rect_cols;
        logic [FW-1:0] rect_rows;
        logic [1:0]    mirror_mode;
        logic          source_format;
    } rbm_cfg_t;

    // One classified pixel on its way to the address stage
    typedef struct packed {
        logic [FW-1:0]   row;
        logic [FW-1:0]   col;
        logic [PIXW-1:0] pixel;
        logic            outside;
        logic            last;
    } rbm_entry_t;

    typedef struct packed {
        logic           full;
        logic           valid;
        logic [QCW-1:0] count;
    } rbm_q_stat_t;

    // Keep the top bits of each RGB888 color
    function automatic logic [PIXW-1:0] pack_565(input logic [INW-1:0] c);
        logic [INW-1:0] b;
        logic [INW-1:0] g;
        logic [INW-1:0] r;
        b = c >> 3;
        g = c >> 5;
        r = c >> 8;
        return (b[PIXW-1:0] & MASK_B) | (g[PIXW-1:0] & MASK_G) | (r[PIXW-1:0] & MASK_R);
    endfunction

endpackage

/* sv/rect_blit_mirror_address_gen.sv */
// Rectangle blit writer for a 16-bit framebuffer, with mirroring and RGB888 packing.
// Holds the register file; instantiates rbm_front, rbm_queue and rbm_back.
// Depends on rbm_pkg and rect_blit_mirror_address_gen_assert.svh.
//
// Usage: program the rectangle, frame size, mirror mode and source format on the
// cfg channel while idle, then stream source pixels in raster order on s_axis.
// Every pixel yields one item on m_axis: the word index and the RGB565 pixel in
// m_tdata, out_of_frame in m_tuser (index is zero then; skip the write), and
// m_tlast on the final pixel of the rectangle, after which the counters wrap.
// From input accept to m_tvalid, a pixel is first written into the queue, then
// loaded into the row-times-pitch multiply stage, and its column sum is then
// loaded into the output register. Throughput is one pixel per cycle while m_tready
// is high; each stage, the 12x12 multiply included, takes a new item every cycle.
// When m_tready is low the output register, the multiplier stage and then the
// four-entry queue fill before s_tready drops.
// Reset clears the counters, the queue and the valid flags and restores the
// register defaults (480x272 frame, 1x1 rectangle at the origin, no mirroring,
// RGB565 passthrough). cfg_ready is always high.
`include "rect_blit_mirror_address_gen_assert.svh"

module rect_blit_mirror_address_gen #(
    parameter int MAX_DIM = 2048
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rbm_pkg::CIW-1:0]   cfg_index,
    input  logic [rbm_pkg::FW-1:0]    cfg_data,
    // Source pixels
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [rbm_pkg::INW-1:0]   s_tdata,   // [23:0] pixel_in
    // Framebuffer writes
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [rbm_pkg::DW-1:0]    m_tdata,   // [21:0] write_index, [37:22] pixel_out
    output logic                      m_tuser,   // [0] out_of_frame
    output logic                      m_tlast    // last_pixel
);

    rbm_pkg::rbm_cfg_t          cfg_reg, cfg_next;
    rbm_pkg::rbm_entry_t        wr_entry;
    rbm_pkg::rbm_entry_t        rd_entry;
    rbm_pkg::rbm_q_stat_t       q_stat;
    logic                       q_push;
    logic                       q_pop;
    logic [rbm_pkg::IDXW-1:0]   out_index;
    logic [rbm_pkg::PIXW-1:0]   out_pixel;

    assign cfg_ready = 1'b1;

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (rbm_pkg::cfg_reg_t'(cfg_index))
                rbm_pkg::REG_FRAME_WIDTH:   cfg_next.frame_width   = cfg_data;
                rbm_pkg::REG_FRAME_HEIGHT:  cfg_next.frame_height  = cfg_data;
                rbm_pkg::REG_RECT_LEFT:     cfg_next.rect_left     = cfg_data[rbm_pkg::OW-1:0];
                rbm_pkg::REG_RECT_TOP:      cfg_next.rect_top      = cfg_data[rbm_pkg::OW-1:0];
                rbm_pkg::REG_RECT_COLS:     cfg_next.rect_cols     = cfg_data;
                rbm_pkg::REG_RECT_ROWS:     cfg_next.rect_rows     = cfg_data;
                rbm_pkg::REG_MIRROR_MODE:   cfg_next.mirror_mode   = cfg_data[1:0];
                rbm_pkg::REG_SOURCE_FORMAT: cfg_next.source_format = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width   <= rbm_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height  <= rbm_pkg::RST_FRAME_HEIGHT;
            cfg_reg.rect_left     <= '0;
            cfg_reg.rect_top      <= '0;
            cfg_reg.rect_cols     <= rbm_pkg::RST_RECT_EXTENT;
            cfg_reg.rect_rows     <= rbm_pkg::RST_RECT_EXTENT;
            cfg_reg.mirror_mode   <= '0;
            cfg_reg.source_format <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rbm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_pixel (s_tdata),
        .q_full   (q_stat.full),
        .in_ready (s_tready),
        .q_push   (q_push),
        .q_entry  (wr_entry)
    );

    rbm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (wr_entry),
        .pop      (q_pop),
        .rd_entry (rd_entry),
        .stat     (q_stat)
    );

    rbm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_width (cfg_reg.frame_width),
        .q_valid     (q_stat.valid),
        .q_entry     (rd_entry),
        .q_pop       (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_index     (out_index),
        .m_pixel     (out_pixel),
        .m_outside   (m_tuser),
        .m_last      (m_tlast)
    );

    // Pack the result fields, pad to whole bytes
    assign m_tdata = {(rbm_pkg::DW - rbm_pkg::IDXW - rbm_pkg::PIXW)'(0), out_pixel, out_index};

    // An off-frame result never carries a write address
    `RBM_ASSERT_NOW(a_oof_index_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata[rbm_pkg::IDXW-1:0] == '0)
    // Queue occupancy stays within its depth
    `RBM_ASSERT_NOW(a_queue_bound, aclk, aresetn, 1'b1, q_stat.count <= rbm_pkg::QDEPTH)
    // A push without a pop grows the queue by one
    `RBM_ASSERT_NEXT(a_queue_grow, aclk, aresetn, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1)

endmodule

/* sv/rbm_front.sv */
// Front end of the blit writer: raster counters, mirroring and frame check.
// Depends on rbm_pkg; pushes classified pixels into rbm_queue.
module rbm_front #(
    parameter int MAX_DIM = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rbm_pkg::rbm_cfg_t    cfg,
    input  logic                 in_valid,
    input  logic [rbm_pkg::INW-1:0] in_pixel,
    input  logic                 q_full,
    output logic                 in_ready,
    output logic                 q_push,
    output rbm_pkg::rbm_entry_t  q_entry
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = CW + 1;
    localparam int XW = (EW > rbm_pkg::FW) ? EW : rbm_pkg::FW;
    localparam int PW = ((CW > rbm_pkg::FW) ? CW : rbm_pkg::FW) + 2;

    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [CW-1:0] row_cnt_reg, row_cnt_next;
    logic [XW-1:0] last_col;
    logic [XW-1:0] last_row;
    logic          col_end;
    logic          row_end;
    logic [PW-1:0] trow;
    logic [PW-1:0] tcol;
    logic          outside;

    // Clamp an extent to one..MAX_DIM
    function automatic logic [XW-1:0] extent(input logic [rbm_pkg::FW-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        if (x == '0) begin
            return XW'(1);
        end else if (x > XW'(MAX_DIM)) begin
            return XW'(MAX_DIM);
        end
        return x;
    endfunction

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Find the ends of the current row and of the rectangle
    always_comb begin
        last_col = extent(cfg.rect_cols) - XW'(1);
        last_row = extent(cfg.rect_rows) - XW'(1);
        col_end  = XW'(col_cnt_reg) >= last_col;
        row_end  = XW'(row_cnt_reg) >= last_row;
    end

    // Mirror the target position and check it against the frame
    always_comb begin
        if (cfg.mirror_mode[0]) begin
            trow = PW'(cfg.frame_height) - PW'(1) - PW'(cfg.rect_top) - PW'(row_cnt_reg);
        end else begin
            trow = PW'(cfg.rect_top) + PW'(row_cnt_reg);
        end
        if (cfg.mirror_mode[1]) begin
            tcol = PW'(cfg.frame_width) - PW'(1) - PW'(cfg.rect_left) - PW'(col_cnt_reg);
        end else begin
            tcol = PW'(cfg.rect_left) + PW'(col_cnt_reg);
        end
        outside = trow[PW-1] || (trow >= PW'(cfg.frame_height)) ||
                  tcol[PW-1] || (tcol >= PW'(cfg.frame_width));
    end

    // Build the queue entry; an outside target gets row and column zero
    always_comb begin
        q_entry.row     = outside ? '0 : trow[rbm_pkg::FW-1:0];
        q_entry.col     = outside ? '0 : tcol[rbm_pkg::FW-1:0];
        q_entry.pixel   = cfg.source_format ? rbm_pkg::pack_565(in_pixel)
                                            : in_pixel[rbm_pkg::PIXW-1:0];
        q_entry.outside = outside;
        q_entry.last    = col_end && row_end;
    end

    // Advance the raster counters, wrap after the last pixel
    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (q_push) begin
            if (col_end) begin
                col_cnt_next = '0;
                row_cnt_next = row_end ? '0 : row_cnt_reg + CW'(1);
            end else begin
                col_cnt_next = col_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

/* sv/rbm_queue.sv */
// Short queue that decouples the front end from the address stage.
// Depends on rbm_pkg for the entry type and depth.
module rbm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  rbm_pkg::rbm_entry_t   wr_entry,
    input  logic                  pop,
    output rbm_pkg::rbm_entry_t   rd_entry,
    output rbm_pkg::rbm_q_stat_t  stat
);

    rbm_pkg::rbm_entry_t           mem_reg [rbm_pkg::QDEPTH];
    logic [rbm_pkg::QPW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [rbm_pkg::QPW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [rbm_pkg::QCW-1:0]       count_reg, count_next;

    assign rd_entry   = mem_reg[rd_ptr_reg];
    assign stat.full  = count_reg == rbm_pkg::QCW'(rbm_pkg::QDEPTH);
    assign stat.valid = count_reg != '0;
    assign stat.count = count_reg;

    // Advance pointers and track occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + rbm_pkg::QPW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + rbm_pkg::QPW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + rbm_pkg::QCW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - rbm_pkg::QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

/* sv/rbm_back.sv */
// Back end of the blit writer: row times pitch, plus column, into the output register.
// Depends on rbm_pkg; pops entries from rbm_queue.
module rbm_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [rbm_pkg::FW-1:0]    frame_width,
    input  logic                      q_valid,
    input  rbm_pkg::rbm_entry_t       q_entry,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [rbm_pkg::IDXW-1:0]  m_index,
    output logic [rbm_pkg::PIXW-1:0]  m_pixel,
    output logic                      m_outside,
    output logic                      m_last
);

    localparam int PRW = 2 * rbm_pkg::FW;

    logic                       a_valid_reg, a_valid_next;
    logic [PRW-1:0]             a_prod_reg;
    logic [rbm_pkg::FW-1:0]     a_col_reg;
    logic [rbm_pkg::PIXW-1:0]   a_pixel_reg;
    logic                       a_outside_reg;
    logic                       a_last_reg;
    logic                       m_valid_reg, m_valid_next;
    logic [rbm_pkg::IDXW-1:0]   m_index_reg;
    logic [rbm_pkg::PIXW-1:0]   m_pixel_reg;
    logic                       m_outside_reg;
    logic                       m_last_reg;
    logic                       b_en;
    logic                       a_en;

    // Move each stage when the one after it frees up
    assign b_en  = !m_valid_reg || m_ready;
    assign a_en  = !a_valid_reg || b_en;
    assign q_pop = q_valid && a_en;

    always_comb begin
        a_valid_next = a_en ? q_valid : a_valid_reg;
        m_valid_next = b_en ? a_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Multiply the target row by the row pitch
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_prod_reg    <= PRW'(q_entry.row) * PRW'(frame_width);
            a_col_reg     <= q_entry.col;
            a_pixel_reg   <= q_entry.pixel;
            a_outside_reg <= q_entry.outside;
            a_last_reg    <= q_entry.last;
        end
    end

    // Add the column and hold the result until taken
    always_ff @(posedge aclk) begin
        if (b_en && a_valid_reg) begin
            m_index_reg   <= a_prod_reg[rbm_pkg::IDXW-1:0] + rbm_pkg::IDXW'(a_col_reg);
            m_pixel_reg   <= a_pixel_reg;
            m_outside_reg <= a_outside_reg;
            m_last_reg    <= a_last_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_index   = m_index_reg;
    assign m_pixel   = m_pixel_reg;
    assign m_outside = m_outside_reg;
    assign m_last    = m_last_reg;

endmodule
